>>> rtl/inflight_range_conflict_table_unit_defines.svh
// assertion macros shared by the rtl
`ifndef INFLIGHT_RANGE_CONFLICT_TABLE_UNIT_DEFINES_SVH
`define INFLIGHT_RANGE_CONFLICT_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRCT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("irct check failed");

// next-cycle implication, checked outside reset
`define IRCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("irct check failed");

`endif

>>> rtl/irct_pkg.sv
package irct_pkg;

    localparam logic OP_TRACK   = 1'b0;
    localparam logic OP_UNTRACK = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_FREE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    // one stored request: inclusive sector range and write mark
    typedef struct packed {
        logic        wr;
        logic [63:0] last;
        logic [63:0] first;
    } t_entry;

endpackage

>>> rtl/inflight_range_conflict_table_unit.sv
// In-flight range conflict table. A track transaction (start high while busy is low) checks
// its inclusive sector range against every valid slot, counts each overlap that is not
// read against read as a race, then takes the lowest free slot; an untrack transaction
// frees the slot named by its tag. Each transaction gives exactly one result, shown for one
// cycle with o_valid; the receiver cannot stall, so it must take the result in that cycle.
// A track transaction of nonzero length passes through S_PREP, S_SCAN, S_DRAIN and S_FIN to its
// result, with the single range comparator walking the slot memory one slot a cycle through
// its one read port; untrack and zero-length transactions give their result from S_PREP. busy falls
// in the result cycle, so the next transaction may be accepted alongside the result.
// o_active_count and o_race_total show the live counters and are valid in the result cycle.
module inflight_range_conflict_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [63:0] i_start_sector,
    input  logic [31:0] i_sector_count,
    input  logic        i_is_write,
    input  logic [4:0]  i_entry_tag,
    output logic        o_valid,
    output logic [4:0]  o_assigned_tag,
    output logic        o_was_tracked,
    output logic [5:0]  o_conflict_count,
    output logic [5:0]  o_active_count,
    output logic [63:0] o_race_total,
    output logic [1:0]  o_status
);
    import irct_pkg::*;
    `include "inflight_range_conflict_table_unit_defines.svh"

    localparam int IW = $clog2(TABLE_DEPTH);      // slot index width
    localparam int CW = $clog2(TABLE_DEPTH + 1);  // count width, holds the depth itself

    // control state
    t_state                 r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [CW-1:0]          r_in_flight, n_in_flight;
    logic [63:0]            r_race, n_race;
    logic                   r_out_vld, n_out_vld;
    logic                   r_pipe_vld, n_pipe_vld;   // compare stage holds a valid slot

    // transaction and scan payload
    logic        r_op;
    logic [63:0] r_first, n_first;
    logic [63:0] r_last, n_last;
    logic [31:0] r_count;
    logic        r_wr;
    logic [4:0]  r_tag;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [IW-1:0] r_free, n_free;
    logic [CW-1:0] r_conf, n_conf;

    // result registers
    logic [4:0] r_o_tag, n_o_tag;
    logic       r_o_trk, n_o_trk;
    logic [5:0] r_o_conf, n_o_conf;
    logic [1:0] r_o_stat, n_o_stat;

    // slot memory, one write and one registered read port
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    logic   mem_we;
    t_entry mem_wdata;

    logic [64:0] end_sum;
    logic        tag_in_range;
    logic [IW-1:0] tag_idx;
    logic        hit;

    assign end_sum      = {1'b0, r_first} + 65'(r_count - 32'd1);
    assign tag_in_range = 32'(r_tag) < TABLE_DEPTH;
    assign tag_idx      = IW'(r_tag);
    // overlap of inclusive ranges, not a race when both sides read
    assign hit = r_pipe_vld && (r_first <= r_rd.last) && (r_rd.first <= r_last)
                 && (r_wr || r_rd.wr);

    assign mem_wdata = '{wr: r_wr, last: r_last, first: r_first};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_free] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_in_flight <= '0;
            r_race      <= '0;
            r_out_vld   <= 1'b0;
            r_pipe_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_in_flight <= n_in_flight;
            r_race      <= n_race;
            r_out_vld   <= n_out_vld;
            r_pipe_vld  <= n_pipe_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_op;
            r_count <= i_sector_count;
            r_wr    <= i_is_write;
            r_tag   <= i_entry_tag;
        end
        r_first  <= n_first;
        r_last   <= n_last;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_free   <= n_free;
        r_conf   <= n_conf;
        r_o_tag  <= n_o_tag;
        r_o_trk  <= n_o_trk;
        r_o_conf <= n_o_conf;
        r_o_stat <= n_o_stat;
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_in_flight = r_in_flight;
        n_race      = r_race;
        n_out_vld   = 1'b0;
        n_pipe_vld  = 1'b0;
        n_first     = r_first;
        n_last      = r_last;
        n_idx       = r_idx;
        n_found     = r_found;
        n_free      = r_free;
        n_conf      = r_conf;
        n_o_tag     = r_o_tag;
        n_o_trk     = r_o_trk;
        n_o_conf    = r_o_conf;
        n_o_stat    = r_o_stat;
        mem_we      = 1'b0;

        // compare stage, one slot behind the read address
        if (hit) begin
            n_conf = r_conf + CW'(1);
            n_race = r_race + 64'd1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_first = i_start_sector;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_o_tag  = '0;
                n_o_trk  = 1'b0;
                n_o_conf = '0;
                if (r_op == OP_UNTRACK) begin
                    if (tag_in_range && r_valid[tag_idx]) begin
                        n_valid[tag_idx] = 1'b0;
                        n_in_flight      = r_in_flight - CW'(1);
                        n_o_stat         = ST_OK;
                    end else begin
                        n_o_stat = ST_FREE;
                    end
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_count == '0) begin
                    n_o_stat  = ST_ZERO;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    // saturate the end sector on overflow
                    n_last  = end_sum[64] ? '1 : end_sum[63:0];
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_free  = '0;
                    n_conf  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pipe_vld = r_valid[r_idx];
                if (!r_found && !r_valid[r_idx]) begin
                    n_found = 1'b1;
                    n_free  = r_idx;
                end
                if (r_idx == IW'(TABLE_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_o_conf = 6'(r_conf);
                if (r_found) begin
                    mem_we          = 1'b1;
                    n_valid[r_free] = 1'b1;
                    n_in_flight     = r_in_flight + CW'(1);
                    n_o_tag         = 5'(r_free);
                    n_o_trk         = 1'b1;
                    n_o_stat        = ST_OK;
                end else begin
                    n_o_tag  = '0;
                    n_o_trk  = 1'b0;
                    n_o_stat = ST_FULL;
                end
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_out_vld;
    assign o_assigned_tag   = r_o_tag;
    assign o_was_tracked    = r_o_trk;
    assign o_conflict_count = r_o_conf;
    assign o_active_count   = 6'(r_in_flight);
    assign o_race_total     = r_race;
    assign o_status         = r_o_stat;

    // an accepted transaction keeps busy high in the cycle after acceptance
    `IRCT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `IRCT_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // live count tracks the valid bits
    `IRCT_ASSERT_SAME(a_count_match, i_clk, i_rst_n, 1'b1,
                      32'(r_in_flight) == $countones(r_valid))
    `IRCT_ASSERT_SAME(a_tracked_ok, i_clk, i_rst_n, o_valid && o_was_tracked,
                      o_status == ST_OK)
    // races only counted while the compare stage runs
    `IRCT_ASSERT_SAME(a_race_scan, i_clk, i_rst_n, r_race != $past(r_race),
                      r_state == S_SCAN || r_state == S_DRAIN || r_state == S_FIN)

endmodule

>>> sim/irct_conflict_checker.sv
module irct_conflict_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_op,
    input  logic [63:0] i_start_sector,
    input  logic [31:0] i_sector_count,
    input  logic        i_is_write,
    input  logic [4:0]  i_entry_tag,
    input  logic        i_valid,
    input  logic [4:0]  i_assigned_tag,
    input  logic        i_was_tracked,
    input  logic [5:0]  i_conflict_count,
    input  logic [5:0]  i_active_count,
    input  logic [63:0] i_race_total,
    input  logic [1:0]  i_status,
    output int          o_outstanding,
    output int          o_fail_count,
    output int          o_full_results,
    output logic [63:0] o_race_seen
);
    import irct_pkg::*;

    typedef struct packed {
        logic [4:0]  tag;
        logic        tracked;
        logic [5:0]  conflicts;
        logic [5:0]  active;
        logic [63:0] races;
        logic [1:0]  status;
    } t_table_result;

    // shadow of the request table
    bit          slot_valid [TABLE_DEPTH];
    logic [63:0] slot_first [TABLE_DEPTH];
    logic [63:0] slot_last  [TABLE_DEPTH];
    bit          slot_write [TABLE_DEPTH];
    int          live_count;
    logic [63:0] race_sum;

    t_table_result awaited_results [$];
    int            mismatches   = 0;
    int            full_results = 0;
    int            awaiting     = 0;

    assign o_outstanding  = awaiting;
    assign o_fail_count   = mismatches;
    assign o_full_results = full_results;
    assign o_race_seen    = race_sum;

    task automatic report_mismatch(input string msg);
        $display("[%0t] irct mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic track_or_untrack(input logic op, input logic [63:0] first,
                                    input logic [31:0] count, input logic wr,
                                    input logic [4:0] tag);
        t_table_result res;
        logic [64:0]   end_sum;
        logic [63:0]   last;
        int            hits;
        int            free_slot;
        res = '0;
        if (op == OP_UNTRACK) begin
            if (tag >= TABLE_DEPTH || !slot_valid[tag]) begin
                res.status = ST_FREE;
            end else begin
                slot_valid[tag] = 1'b0;
                live_count--;
                res.status = ST_OK;
            end
        end else if (count == 32'd0) begin
            res.status = ST_ZERO;
        end else begin
            // inclusive end, pinned at all ones on overflow
            end_sum = {1'b0, first} + {33'd0, count} - 65'd1;
            last    = end_sum[64] ? {64{1'b1}} : end_sum[63:0];
            hits    = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_valid[i] && first <= slot_last[i] && slot_first[i] <= last
                        && (wr || slot_write[i]))
                    hits++;
            end
            race_sum      = race_sum + 64'(hits);
            res.conflicts = 6'(hits);
            free_slot     = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (!slot_valid[i] && free_slot < 0)
                    free_slot = i;
            end
            if (free_slot < 0) begin
                res.status = ST_FULL;
                full_results++;
            end else begin
                slot_valid[free_slot] = 1'b1;
                slot_first[free_slot] = first;
                slot_last[free_slot]  = last;
                slot_write[free_slot] = wr;
                live_count++;
                res.tag     = 5'(free_slot);
                res.tracked = 1'b1;
                res.status  = ST_OK;
            end
        end
        res.active = 6'(live_count);
        res.races  = race_sum;
        awaited_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_first[i] = '0;
                slot_last[i]  = '0;
                slot_write[i] = 1'b0;
            end
            live_count = 0;
            race_sum   = '0;
            awaited_results.delete();
        end else begin
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no transaction waiting");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_assigned_tag !== want.tag)
                        report_mismatch($sformatf("assigned_tag got %0d want %0d",
                                                  i_assigned_tag, want.tag));
                    if (i_was_tracked !== want.tracked)
                        report_mismatch($sformatf("was_tracked got %0b want %0b",
                                                  i_was_tracked, want.tracked));
                    if (i_conflict_count !== want.conflicts)
                        report_mismatch($sformatf("conflict_count got %0d want %0d",
                                                  i_conflict_count, want.conflicts));
                    if (i_active_count !== want.active)
                        report_mismatch($sformatf("active_count got %0d want %0d",
                                                  i_active_count, want.active));
                    if (i_race_total !== want.races)
                        report_mismatch($sformatf("race_total got %0h want %0h",
                                                  i_race_total, want.races));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                end
            end
            if (i_start && !i_busy)
                track_or_untrack(i_op, i_start_sector, i_sector_count, i_is_write,
                                 i_entry_tag);
        end
        awaiting = awaited_results.size();
    end

endmodule

>>> sim/tb_inflight_range_conflict_table_unit.sv
module tb_inflight_range_conflict_table_unit;
    import irct_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 800;
    localparam int BURST_LEN    = 40;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_op           = OP_TRACK;
    logic [63:0] i_start_sector = '0;
    logic [31:0] i_sector_count = '0;
    logic        i_is_write     = 1'b0;
    logic [4:0]  i_entry_tag    = '0;
    logic        o_valid;
    logic [4:0]  o_assigned_tag;
    logic        o_was_tracked;
    logic [5:0]  o_conflict_count;
    logic [5:0]  o_active_count;
    logic [63:0] o_race_total;
    logic [1:0]  o_status;

    int          outstanding;
    int          fail_count;
    int          full_results;
    logic [63:0] race_seen;

    // sender idling, in cycles per hundred
    int idle_pct = 12;
    int n_track  = 0;
    int n_untrack = 0;
    int n_zero   = 0;

    // 10 time unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    inflight_range_conflict_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_start_sector  (i_start_sector),
        .i_sector_count  (i_sector_count),
        .i_is_write      (i_is_write),
        .i_entry_tag     (i_entry_tag),
        .o_valid         (o_valid),
        .o_assigned_tag  (o_assigned_tag),
        .o_was_tracked   (o_was_tracked),
        .o_conflict_count(o_conflict_count),
        .o_active_count  (o_active_count),
        .o_race_total    (o_race_total),
        .o_status        (o_status)
    );

    // watches both sides of the block, predicts and compares
    irct_conflict_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_start_sector  (i_start_sector),
        .i_sector_count  (i_sector_count),
        .i_is_write      (i_is_write),
        .i_entry_tag     (i_entry_tag),
        .i_valid         (o_valid),
        .i_assigned_tag  (o_assigned_tag),
        .i_was_tracked   (o_was_tracked),
        .i_conflict_count(o_conflict_count),
        .i_active_count  (o_active_count),
        .i_race_total    (o_race_total),
        .i_status        (o_status),
        .o_outstanding   (outstanding),
        .o_fail_count    (fail_count),
        .o_full_results  (full_results),
        .o_race_seen     (race_seen)
    );

    // one transaction: optional idle cycles, then hold start until busy is low at an edge;
    // called and returning at a rising edge, start stays high into the next call
    task automatic send_request(input logic op, input logic [63:0] first,
                                input logic [31:0] count, input logic wr,
                                input logic [4:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_start_sector <= first;
        i_sector_count <= count;
        i_is_write     <= wr;
        i_entry_tag    <= tag;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (op == OP_UNTRACK)
            n_untrack++;
        else if (count == 32'd0)
            n_zero++;
        else
            n_track++;
    endtask

    // mostly a narrow window so ranges collide, with some wide, wrapping and zero lengths
    task automatic pick_range(output logic [63:0] first, output logic [31:0] count);
        int pick;
        pick = $urandom_range(99);
        if (pick < 66) begin
            first = 64'($urandom_range(511));
            count = 32'($urandom_range(64, 1));
        end else if (pick < 76) begin
            // near the top of the sector space, end may saturate
            first = {64{1'b1}} - 64'($urandom_range(300));
            count = 32'($urandom_range(1000, 1));
        end else if (pick < 86) begin
            first = {$urandom, $urandom};
            count = $urandom;
        end else if (pick < 96) begin
            first = 64'($urandom_range(511));
            count = $urandom | 32'h8000_0000;
        end else begin
            first = {$urandom, $urandom};
            count = '0;
        end
    endtask

    initial begin
        logic [63:0] first;
        logic [31:0] count;
        int          mode;
        int          track_pct;
        int          sent;
        int          wait_cycles;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero length, untrack of free slots, read against read, touching ranges,
        // saturated ends, lowest free slot reuse, ignored tag on a track
        send_request(OP_TRACK,   {64{1'b1}},             32'd0,          1'b1, 5'd0);
        send_request(OP_UNTRACK, {64{1'b1}},             {32{1'b1}},     1'b1, 5'd0);
        send_request(OP_UNTRACK, '0,                     '0,             1'b0, 5'd31);
        send_request(OP_TRACK,   64'd100,                32'd10,         1'b0, 5'd0);
        send_request(OP_TRACK,   64'd105,                32'd1,          1'b0, 5'd0);
        send_request(OP_TRACK,   64'd109,                32'd1,          1'b1, 5'd0);
        send_request(OP_TRACK,   64'd110,                32'd5,          1'b0, 5'd0);
        send_request(OP_TRACK,   64'd90,                 32'd10,         1'b1, 5'd0);
        send_request(OP_TRACK,   {64{1'b1}},             {32{1'b1}},     1'b1, 5'd0);
        send_request(OP_TRACK,   64'hFFFF_FFFF_FFFF_FFF0, 32'd32,        1'b0, 5'd0);
        send_request(OP_TRACK,   64'd0,                  {32{1'b1}},     1'b1, 5'd0);
        send_request(OP_UNTRACK, '0,                     '0,             1'b0, 5'd1);
        send_request(OP_TRACK,   64'd106,                32'd2,          1'b1, 5'd31);
        send_request(OP_UNTRACK, '0,                     '0,             1'b0, 5'd1);
        send_request(OP_UNTRACK, '0,                     '0,             1'b0, 5'd1);
        send_request(OP_UNTRACK, '0,                     '0,             1'b0, 5'd30);
        send_request(OP_TRACK,   64'd200,                32'd8,          1'b0, 5'd0);

        // random bursts: fill runs drive the table full, drain runs empty it, mixed between
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(2);
            case (mode)
                0:       track_pct = 90;
                1:       track_pct = 15;
                default: track_pct = 55;
            endcase
            for (int k = 0; k < BURST_LEN; k++) begin
                // sender idles lightly, then heavily, then not at all
                idle_pct = (sent < RANDOM_ITEMS / 3) ? 12 :
                           (sent < 2 * RANDOM_ITEMS / 3) ? 46 : 0;
                pick_range(first, count);
                if ($urandom_range(99) < track_pct)
                    send_request(OP_TRACK, first, count, 1'($urandom), 5'($urandom));
                else
                    send_request(OP_UNTRACK, first, count, 1'($urandom),
                                 5'($urandom_range(31)));
                sent++;
            end
        end
        start <= 1'b0;

        // let the last results come out, then allow one full scan more
        wait_cycles = 0;
        @(negedge i_clk);
        while (outstanding != 0 && wait_cycles < 20 * TABLE_DEPTH) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);
        if (outstanding != 0)
            $display("%0d results never arrived", outstanding);

        $display("sent %0d tracks, %0d untracks and %0d zero-length transactions",
                 n_track, n_untrack, n_zero);
        $display("table-full results seen: %0d, races counted: %0d", full_results, race_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_inflight_range_conflict_table_unit OK");
        end else begin
            $display("tb_inflight_range_conflict_table_unit NOT OK");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("tb_inflight_range_conflict_table_unit NOT OK");
        $finish;
    end

endmodule
